/* design/mcd_pkg.sv */
// Shared types, codes, widths and reset values for the multi-click detector.
package mcd_pkg;

    localparam int SLOTS_DEF  = 5;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TICK_W     = 7;
    localparam int DEAD_W     = 10;
    localparam int IDLE_RST_W = 14;
    localparam int CLICK_W    = 16;
    localparam int CAPS_W     = 5;
    localparam int COUNT_W    = 3;

    localparam logic [TICK_W-1:0]     TICK_RST     = 7'd10;
    localparam logic [DEAD_W-1:0]     DEAD_RST     = 10'd50;
    localparam logic [IDLE_RST_W-1:0] IDLE_RST_RST = 14'd500;
    localparam logic [CLICK_W-1:0]    MIN_RST      = 16'd75;
    localparam logic [CLICK_W-1:0]    MAX_RST      = 16'd250;
    localparam logic [CAPS_W-1:0]     CAPS_RST     = 5'd0;

    // count saturation and the largest count that owns a capability bit
    localparam int COUNT_MAX = 7;
    localparam int FIRE_MAX  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPS     = 3'd5;

    typedef enum logic [1:0] {
        KIND_PRESS = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [COUNT_W-1:0] count;
        logic               fired;
        logic               last;
    } t_result;

endpackage

/* design/mcd_in_if.sv */
// Input channel: one poll tick carrying the sampled button level.
interface mcd_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink (input valid, input pin_level, output ready);
endinterface

/* design/mcd_out_if.sv */
// Output channel: one detector event.
interface mcd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [2:0] click_count;
    logic       action_fired;
    logic       last;

    modport source (output valid, output event_kind, output click_count,
                    output action_fired, output last, input ready);
    modport sink (input valid, input event_kind, input click_count,
                  input action_fired, input last, output ready);
endinterface

/* design/multi_click_detector_unit.sv */
// Multi-click button detector: tick step logic, click ring and result queue.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  i_in     | in  | valid/ready   | pin_level
//  o_out    | out | valid/ready   | event_kind, click_count, action_fired, last
//  i_cfg_*  | in  | write enable  | i_cfg_idx, i_cfg_data
//
// At most one tick is taken per cycle, while i_in.ready is high. Its state update
// and its results are registered at the accepting edge; the results join a
// three-entry result queue whose head shows on o_out. The queue sets the input
// rate: a tick is taken while at most one result is left after this cycle's
// output transaction, so a two-result tick occupies two output transactions.
// Synchronous active-low reset restores register defaults, clears the ring
// and empties the queue.
module multi_click_detector_unit #(
    parameter int SLOTS = mcd_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mcd_in_if.sink                          i_in,
    mcd_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [mcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mcd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int VW = (CW > mcd_pkg::COUNT_W) ? CW : mcd_pkg::COUNT_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam int TW = mcd_pkg::TIMER_W;

    // configuration
    logic [mcd_pkg::TICK_W-1:0]     r_tick;
    logic [mcd_pkg::DEAD_W-1:0]     r_dead;
    logic [mcd_pkg::IDLE_RST_W-1:0] r_idle_rst;
    logic [mcd_pkg::CLICK_W-1:0]    r_min;
    logic [mcd_pkg::CLICK_W-1:0]    r_max;
    logic [mcd_pkg::CAPS_W-1:0]     r_caps;

    // detector state
    logic          r_held;
    logic [TW-1:0] r_press;
    logic [TW-1:0] r_idle;
    logic [TW-1:0] r_len [SLOTS];
    logic [SW-1:0] r_slot;

    logic          n_held;
    logic [TW-1:0] n_press;
    logic [TW-1:0] n_idle;
    logic [TW-1:0] n_len [SLOTS];
    logic [SW-1:0] n_slot;

    // result queue, head at entry 0
    mcd_pkg::t_result r_q [3];
    logic [1:0]       r_qcnt;
    mcd_pkg::t_result n_q [3];
    logic [1:0]       n_qcnt;

    mcd_pkg::t_result res0;
    mcd_pkg::t_result res1;
    logic [1:0]       push;
    logic [1:0]       push_eff;
    logic [1:0]       base;
    logic [VW-1:0]    vcnt;
    logic             acc;
    logic             pop;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [mcd_pkg::TICK_W-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + (TW + 1)'(b);
        return s[TW] ? '1 : s[TW-1:0];
    endfunction

    assign pop         = (r_qcnt != 2'd0) && o_out.ready;
    assign base        = r_qcnt - {1'b0, pop};
    assign i_in.ready  = (base <= 2'd1);
    assign acc         = i_in.valid && i_in.ready;

    assign o_out.valid        = (r_qcnt != 2'd0);
    assign o_out.event_kind   = r_q[0].kind;
    assign o_out.click_count  = r_q[0].count;
    assign o_out.action_fired = r_q[0].fired;
    assign o_out.last         = r_q[0].last;

    // one tick of the detector
    always_comb begin
        n_held  = r_held;
        n_press = r_press;
        n_idle  = r_idle;
        n_len   = r_len;
        n_slot  = r_slot;
        res0    = '0;
        res1    = '0;
        push    = 2'd0;
        vcnt    = '0;
        if (!r_held && (r_press < TW'(r_dead))) begin
            // inside the dead time: advance the press timer, ignore the pin
            n_press = sat_add(r_press, r_tick);
        end else begin
            n_held = i_in.pin_level;
            if (!i_in.pin_level) begin
                if (r_press == '0) begin
                    res0 = '{kind: mcd_pkg::KIND_PRESS, count: '0, fired: 1'b0, last: 1'b1};
                    push = 2'd1;
                end
                n_press = sat_add(r_press, r_tick);
                n_idle  = '0;
            end else begin
                if (r_press != '0) begin
                    n_len[r_slot] = r_press;
                    n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SW'(1);
                end
                n_idle  = sat_add(r_idle, r_tick);
                n_press = '0;
            end
            // a press resets idle time, so evaluation never meets a press start
            if ((n_idle > TW'(r_idle_rst)) && (n_len[0] != '0)) begin
                for (int k = 0; k < SLOTS; k++) begin
                    if ((n_len[k] >= r_min) && (n_len[k] <= r_max)) begin
                        vcnt = vcnt + VW'(1);
                    end
                end
                if (vcnt != '0) begin
                    res0.kind  = mcd_pkg::KIND_COUNT;
                    res0.count = (vcnt > VW'(mcd_pkg::COUNT_MAX)) ?
                                 mcd_pkg::COUNT_W'(mcd_pkg::COUNT_MAX) : vcnt[2:0];
                    res0.fired = (vcnt <= VW'(mcd_pkg::FIRE_MAX)) ?
                                 r_caps[vcnt[2:0] - 3'd1] : 1'b0;
                    res0.last  = 1'b0;
                    res1 = '{kind: mcd_pkg::KIND_DONE, count: '0, fired: 1'b0, last: 1'b1};
                    push = 2'd2;
                end else begin
                    res0 = '{kind: mcd_pkg::KIND_DONE, count: '0, fired: 1'b0, last: 1'b1};
                    push = 2'd1;
                end
                for (int k = 0; k < SLOTS; k++) begin
                    n_len[k] = '0;
                end
                n_slot = '0;
            end
        end
    end

    // queue: drop the head on an output transaction, append this tick's results
    always_comb begin
        push_eff = acc ? push : 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_q[k] = (pop && k < 2) ? r_q[k + 1] : r_q[k];
            if ((push_eff != 2'd0) && (2'(k) == base)) begin
                n_q[k] = res0;
            end
            if ((push_eff == 2'd2) && (2'(k) == 2'(base + 2'd1))) begin
                n_q[k] = res1;
            end
        end
        n_qcnt = base + push_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= mcd_pkg::TICK_RST;
            r_dead     <= mcd_pkg::DEAD_RST;
            r_idle_rst <= mcd_pkg::IDLE_RST_RST;
            r_min      <= mcd_pkg::MIN_RST;
            r_max      <= mcd_pkg::MAX_RST;
            r_caps     <= mcd_pkg::CAPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcd_pkg::CFG_TICK:     r_tick     <= i_cfg_data[mcd_pkg::TICK_W-1:0];
                mcd_pkg::CFG_DEAD:     r_dead     <= i_cfg_data[mcd_pkg::DEAD_W-1:0];
                mcd_pkg::CFG_IDLE_RST: r_idle_rst <= i_cfg_data[mcd_pkg::IDLE_RST_W-1:0];
                mcd_pkg::CFG_MIN:      r_min      <= i_cfg_data[mcd_pkg::CLICK_W-1:0];
                mcd_pkg::CFG_MAX:      r_max      <= i_cfg_data[mcd_pkg::CLICK_W-1:0];
                mcd_pkg::CFG_CAPS:     r_caps     <= i_cfg_data[mcd_pkg::CAPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b1;
            r_press <= '0;
            r_idle  <= '0;
            r_slot  <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_len[k] <= '0;
            end
        end else if (acc) begin
            r_held  <= n_held;
            r_press <= n_press;
            r_idle  <= n_idle;
            r_slot  <= n_slot;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

/* design/mcd_checker.sv */
// Port-level checker for the multi-click detector, with its bind statement.
module mcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_event_kind,
    input logic [2:0] i_click_count,
    input logic       i_action_fired,
    input logic       i_last
);

    // hold an offered result until its transaction
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transaction");

    a_no_bad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_kind == mcd_pkg::KIND_PRESS) ||
                        (i_event_kind == mcd_pkg::KIND_COUNT) ||
                        (i_event_kind == mcd_pkg::KIND_DONE))
        else $error("undefined event kind");

    a_count_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_kind == mcd_pkg::KIND_COUNT) |->
            !i_last && (i_click_count != 3'd0))
        else $error("count result with last set or zero count");

    a_count_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_event_kind == mcd_pkg::KIND_COUNT) |=>
            i_out_valid && (i_event_kind == mcd_pkg::KIND_DONE) && i_last &&
            !i_action_fired && (i_click_count == 3'd0))
        else $error("count result not followed by a done result");

endmodule

bind multi_click_detector_unit mcd_checker u_mcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_event_kind   (o_out.event_kind),
    .i_click_count  (o_out.click_count),
    .i_action_fired (o_out.action_fired),
    .i_last         (o_out.last)
);
